// ===== hdl/text_encoding_detector_macros.svh =====
// Assertion macros for the text encoding detector.
// Included by the RTL modules that carry concurrent checks; needs a clk and rst in scope.
`ifndef TEXT_ENCODING_DETECTOR_MACROS_SVH
`define TEXT_ENCODING_DETECTOR_MACROS_SVH

// Check a property on every rising edge outside reset.
`define TED_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define TED_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/ted_pkg.sv =====
// Shared types, codes and decode functions of the text encoding detector.
// No dependencies; imported by every module of the block.
`default_nettype none

package ted_pkg;

  typedef enum logic [1:0] {
    PAGE_UTF8 = 2'd0,
    PAGE_BE   = 2'd1,
    PAGE_LE   = 2'd2,
    PAGE_ANSI = 2'd3
  } page_t;

  // Allowed range of the next continuation byte.
  typedef enum logic [2:0] {
    RNG_80_BF = 3'd0,
    RNG_A0_BF = 3'd1,
    RNG_80_9F = 3'd2,
    RNG_90_BF = 3'd3,
    RNG_80_8F = 3'd4
  } rng_t;

  typedef struct packed {
    page_t page;
    logic  valid;
  } result_t;

  localparam int unsigned PrefixLen = 4;

  function automatic logic cont_ok(input logic [7:0] b, input rng_t cls);
    logic ok;
    unique case (cls)
      RNG_A0_BF: ok = (b >= 8'hA0) && (b <= 8'hBF);
      RNG_80_9F: ok = (b >= 8'h80) && (b <= 8'h9F);
      RNG_90_BF: ok = (b >= 8'h90) && (b <= 8'hBF);
      RNG_80_8F: ok = (b >= 8'h80) && (b <= 8'h8F);
      default:   ok = (b >= 8'h80) && (b <= 8'hBF);
    endcase
    return ok;
  endfunction

  function automatic page_t choose_page(input logic [31:0] prefix, input logic valid);
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    page_t      page;
    b0 = prefix[31:24];
    b1 = prefix[23:16];
    b2 = prefix[15:8];
    b3 = prefix[7:0];
    priority if (b0 == 8'hEF && b1 == 8'hBB && b2 == 8'hBF) page = PAGE_UTF8;
    else if (b0 == 8'hFE && b1 == 8'hFF) page = PAGE_BE;
    else if (b0 == 8'hFF && b1 == 8'hFE) page = PAGE_LE;
    else if (b0 == 8'h00 && (b1 == 8'h5B || b1 == 8'h7B)) page = PAGE_BE;
    else if ((b0 == 8'h5B || b0 == 8'h7B) && b1 == 8'h00) page = PAGE_LE;
    else if (b0 == 8'h2F && b1 == 8'h00 && b2 == 8'h2F && b3 == 8'h00) page = PAGE_LE;
    else if (b0 == 8'h00 && b1 == 8'h2F && b2 == 8'h00 && b3 == 8'h2F) page = PAGE_BE;
    else if (valid) page = PAGE_UTF8;
    else page = PAGE_ANSI;
    return page;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/ted_scan.sv =====
// Per-byte scanner: prefix capture, UTF-8 validation state and the end-of-blob decision.
// Depends on ted_pkg and text_encoding_detector_macros.svh.
`default_nettype none

module ted_scan (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            fire,
  input  wire logic [7:0]      data_byte,
  input  wire logic            last_byte,
  output ted_pkg::result_t     result,
  output logic                 result_push
);
  import ted_pkg::*;
  `include "text_encoding_detector_macros.svh"

  logic [31:0] prefix_bytes;
  logic [2:0]  bytes_seen;
  logic [1:0]  cont_left;
  rng_t        range_class;
  logic        text_valid;
  logic        zero_seen;

  logic [31:0] prefix_next;
  logic [2:0]  seen_next;
  logic [1:0]  cont_next;
  rng_t        range_next;
  logic        valid_next;
  logic        zero_next;
  logic        valid_end;

  always_comb begin
    prefix_next = prefix_bytes;
    seen_next   = bytes_seen;
    if (bytes_seen < 3'(PrefixLen)) begin
      seen_next = bytes_seen + 3'd1;
      unique case (bytes_seen[1:0])
        2'd0: prefix_next[31:24] = data_byte;
        2'd1: prefix_next[23:16] = data_byte;
        2'd2: prefix_next[15:8]  = data_byte;
        default: prefix_next[7:0] = data_byte;
      endcase
    end

    cont_next  = cont_left;
    range_next = range_class;
    valid_next = text_valid;
    zero_next  = zero_seen;
    if (!zero_seen) begin
      if (data_byte == 8'h00) begin
        zero_next = 1'b1;
        if (cont_left != 2'd0) begin
          valid_next = 1'b0;
          cont_next  = 2'd0;
          range_next = RNG_80_BF;
        end
      end else if (text_valid) begin
        if (cont_left != 2'd0) begin
          if (cont_ok(data_byte, range_class)) begin
            cont_next  = cont_left - 2'd1;
            range_next = RNG_80_BF;
          end else begin
            valid_next = 1'b0;
            cont_next  = 2'd0;
            range_next = RNG_80_BF;
          end
        end else begin
          priority if (data_byte == 8'h09 || data_byte == 8'h0A || data_byte == 8'h0D ||
                       (data_byte >= 8'h20 && data_byte <= 8'h7E)) begin
            cont_next = 2'd0;
          end else if (data_byte >= 8'hC2 && data_byte <= 8'hDF) begin
            cont_next  = 2'd1;
            range_next = RNG_80_BF;
          end else if (data_byte == 8'hE0) begin
            cont_next  = 2'd2;
            range_next = RNG_A0_BF;
          end else if (data_byte == 8'hED) begin
            cont_next  = 2'd2;
            range_next = RNG_80_9F;
          end else if (data_byte >= 8'hE1 && data_byte <= 8'hEF) begin
            cont_next  = 2'd2;
            range_next = RNG_80_BF;
          end else if (data_byte == 8'hF0) begin
            cont_next  = 2'd3;
            range_next = RNG_90_BF;
          end else if (data_byte >= 8'hF1 && data_byte <= 8'hF3) begin
            cont_next  = 2'd3;
            range_next = RNG_80_BF;
          end else if (data_byte == 8'hF4) begin
            cont_next  = 2'd3;
            range_next = RNG_80_8F;
          end else begin
            valid_next = 1'b0;
            cont_next  = 2'd0;
            range_next = RNG_80_BF;
          end
        end
      end
    end

    // a blob that stops inside a sequence is invalid
    valid_end    = valid_next && (zero_next || cont_next == 2'd0);
    result.page  = choose_page(prefix_next, valid_end);
    result.valid = valid_end;
    result_push  = fire && last_byte;
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && last_byte)) begin
      bytes_seen  <= 3'd0;
      cont_left   <= 2'd0;
      range_class <= RNG_80_BF;
      text_valid  <= 1'b1;
      zero_seen   <= 1'b0;
    end else if (fire) begin
      bytes_seen  <= seen_next;
      cont_left   <= cont_next;
      range_class <= range_next;
      text_valid  <= valid_next;
      zero_seen   <= zero_next;
    end
  end

  // prefix is payload; clear it at blob end so short blobs read as zero
  always_ff @(posedge clk) begin
    if (rst || (fire && last_byte)) begin
      prefix_bytes <= 32'd0;
    end else if (fire) begin
      prefix_bytes <= prefix_next;
    end
  end

  `TED_ASSERT(a_blob_restart, (fire && last_byte) |=>
    (bytes_seen == 3'd0 && cont_left == 2'd0 && text_valid && !zero_seen),
    "scanner state not cleared after last byte")
  `TED_ASSERT(a_cont_only_live, (cont_left != 2'd0) |-> (text_valid && !zero_seen),
    "continuation pending after error or zero byte")
  `TED_ASSERT(a_seen_sat, bytes_seen <= 3'(PrefixLen), "prefix count past four")

endmodule

`default_nettype wire

// ===== hdl/ted_outq.sv =====
// Two-entry result queue that decouples the scanner from a stalled consumer.
// Depends on ted_pkg and text_encoding_detector_macros.svh.
`default_nettype none

module ted_outq (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire ted_pkg::result_t push_data,
  output logic                  full,
  output logic                  head_valid,
  output ted_pkg::result_t      head,
  input  wire logic             pop_ready
);
  import ted_pkg::*;
  `include "text_encoding_detector_macros.svh"

  result_t    slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop        = head_valid && pop_ready;
  assign head_valid = (count != 2'd0);
  assign full       = (count == 2'd2);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  `TED_ASSERT(a_no_overflow, full |-> !push, "push into full result queue")
  `TED_ASSERT(a_count_range, count <= 2'd2, "result queue count out of range")
  `TED_ASSERT(a_ptr_track, (count == 2'd0 || count == 2'd2) |-> (wr_ptr == rd_ptr),
    "queue pointers disagree with count")

endmodule

`default_nettype wire

// ===== hdl/text_encoding_detector.sv =====
// Text encoding detector: one byte transfer per cycle while in_ready is high.
// Blob results are queued as each last byte transfers; out_valid gives them in order.
// A two-entry result queue keeps bytes flowing while a result waits; in_ready drops
// only when both queue slots hold results not yet taken.
// Reset (rst, synchronous) clears the scanner to a fresh blob and empties the queue.
`default_nettype none

module text_encoding_detector (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      code_page,
  output logic            utf8_valid
);
  import ted_pkg::*;

  logic    fire;
  logic    push;
  logic    full;
  result_t scan_result;
  result_t head;

  assign in_ready = !full;
  assign fire     = in_valid && in_ready;

  ted_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .data_byte   (data_byte),
    .last_byte   (last_byte),
    .result      (scan_result),
    .result_push (push)
  );

  ted_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (scan_result),
    .full       (full),
    .head_valid (out_valid),
    .head       (head),
    .pop_ready  (out_ready)
  );

  assign code_page  = head.page;
  assign utf8_valid = head.valid;

endmodule

`default_nettype wire
